### sv/icmw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmw_pkg
// Shared widths, register codes and controller/datapath handshake types for
// the interval coverage max window unit.
// ----------------------------------------------------------------------------
package icmw_pkg;

   localparam int ROW_W       = 10;  // input row bound width
   localparam int COL_W       = 11;  // column count / height register width
   localparam int CNT_W       = 11;  // per-row start/end count width
   localparam int OUT_W       = 21;  // result width
   localparam int SUM_W       = 2 * COL_W;  // window sums and count*height
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = COL_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CORRIDOR_HEIGHT = 2'd1;

   localparam logic [COL_W-1:0] COLUMN_COUNT_RESET    = 11'd1024;
   localparam logic [COL_W-1:0] CORRIDOR_HEIGHT_RESET = 11'd1;

   typedef struct packed {
      logic accept;      // capture bounds, read both count stores
      logic update;      // write back incremented counts
      logic sweep_step;  // read and zero one row, build coverage
      logic win_step;    // read one window row pair
      logic mul;         // register count * height
      logic load_out;    // load the result register
   } icmw_cmd_type;

   typedef struct packed {
      logic row_last;    // sweep at the last row of the stores
      logic win_last;    // window pass at the last active row
      logic set_done;    // the set is complete after this word
      logic out_free;    // result register can take a new word
   } icmw_status_type;

endpackage

### sv/icmw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmw_req_if / icmw_rsp_if
// Valid/ready channels carrying interval words in and result words out.
// ----------------------------------------------------------------------------
interface icmw_req_if
   import icmw_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] gap_low;
   logic [ROW_W-1:0] gap_high;

   modport source (output valid, output gap_low, output gap_high, input ready);
   modport sink   (input valid, input gap_low, input gap_high, output ready);
endinterface

interface icmw_rsp_if
   import icmw_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] min_energy;

   modport source (output valid, output min_energy, input ready);
   modport sink   (input valid, input min_energy, output ready);
endinterface

### sv/icmw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmw_ctrl
// Sequencer: clear after reset, take interval words, then run the coverage
// sweep, the window pass and the result handoff for each completed set.
// ----------------------------------------------------------------------------
module icmw_ctrl
   import icmw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output icmw_cmd_type    cmd,
   input  icmw_status_type status
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_LOAD,
      S_UPDATE,
      S_SWEEP,
      S_WINDOW,
      S_MUL,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.sweep_step = 1'b1;
            if (status.row_last) state_in = S_LOAD;
         end
         S_LOAD: begin
            if (req_valid && ready_ff) begin
               cmd.accept = 1'b1;
               state_in   = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.set_done ? S_SWEEP : S_LOAD;
         end
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.row_last) state_in = S_WINDOW;
         end
         S_WINDOW: begin
            cmd.win_step = 1'b1;
            if (status.win_last) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the result register frees up
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_LOAD;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_LOAD);
      end
   end

   assign req_ready = ready_ff;

endmodule

### sv/icmw_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmw_dpath
// Count stores, coverage store, running and window sums, configuration
// registers and the result register.
// ----------------------------------------------------------------------------
module icmw_dpath
   import icmw_pkg::*;
#(
   parameter int MAX_ROWS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  icmw_cmd_type           cmd,
   output icmw_status_type        status,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [ROW_W-1:0]       req_gap_low,
   input  logic [ROW_W-1:0]       req_gap_high,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OUT_W-1:0]       rsp_min_energy
);

   localparam int AW     = $clog2(MAX_ROWS);
   localparam int CW     = ((AW > COL_W) ? AW : COL_W) + 1;
   localparam int NCAP_I = (MAX_ROWS > 2047) ? 2047 : MAX_ROWS;
   localparam logic [COL_W-1:0] NCAP     = NCAP_I[COL_W-1:0];
   localparam logic [AW-1:0]    ROW_LAST = AW'(MAX_ROWS - 1);

   // configuration
   logic [COL_W-1:0] col_ff, hgt_ff;
   logic [COL_W-1:0] n_eff, h_eff, n_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= COLUMN_COUNT_RESET;
         hgt_ff <= CORRIDOR_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COLUMN_COUNT:    col_ff <= csr_wdata;
            CSR_CORRIDOR_HEIGHT: hgt_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      n_eff = col_ff;
      if (n_eff == '0) n_eff = COL_W'(1);
      if (n_eff > NCAP) n_eff = NCAP;
      h_eff = hgt_ff;
      if (h_eff == '0) h_eff = COL_W'(1);
      if (h_eff > n_eff) h_eff = n_eff;
      n_last = n_eff - COL_W'(1);
   end

   // interval bounds: order, then clamp to the last active row
   logic [ROW_W-1:0] lo_s, hi_s;
   logic [COL_W-1:0] lo_c, hi_c;
   logic [AW-1:0]    lo_addr, hi_addr;

   always_comb begin
      lo_s = (req_gap_low > req_gap_high) ? req_gap_high : req_gap_low;
      hi_s = (req_gap_low > req_gap_high) ? req_gap_low : req_gap_high;
      lo_c = (COL_W'(lo_s) > n_last) ? n_last : COL_W'(lo_s);
      hi_c = (COL_W'(hi_s) > n_last) ? n_last : COL_W'(hi_s);
      lo_addr = AW'(lo_c);
      hi_addr = AW'(hi_c);
   end

   // row counter shared by the sweep and the window pass
   logic [AW-1:0] row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else if (cmd.sweep_step) begin
         row_ff <= (row_ff == ROW_LAST) ? '0 : row_ff + AW'(1);
      end else if (cmd.win_step) begin
         row_ff <= status.win_last ? '0 : row_ff + AW'(1);
      end
   end

   // start/end count stores
   logic [CNT_W-1:0] st_mem [MAX_ROWS];
   logic [CNT_W-1:0] en_mem [MAX_ROWS];
   logic [CNT_W-1:0] st_rd_ff, en_rd_ff;
   logic [AW-1:0]    lo_ff, hi_ff;
   logic [AW-1:0]    st_raddr, en_raddr;

   assign st_raddr = cmd.accept ? lo_addr : row_ff;
   assign en_raddr = cmd.accept ? hi_addr : row_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept || cmd.sweep_step) begin
         st_rd_ff <= st_mem[st_raddr];
         en_rd_ff <= en_mem[en_raddr];
      end
      if (cmd.accept) begin
         lo_ff <= lo_addr;
         hi_ff <= hi_addr;
      end
      if (cmd.update) begin
         st_mem[lo_ff] <= st_rd_ff + CNT_W'(1);
         en_mem[hi_ff] <= en_rd_ff + CNT_W'(1);
      end else if (cmd.sweep_step) begin
         // zero the row as it is read out
         st_mem[row_ff] <= '0;
         en_mem[row_ff] <= '0;
      end
   end

   // words loaded in the current set
   logic [CNT_W-1:0] loaded_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
      end else if (cmd.update && status.set_done) begin
         loaded_ff <= '0;
      end else if (cmd.accept) begin
         loaded_ff <= loaded_ff + CNT_W'(1);
      end
   end

   // coverage: running starts minus ends of earlier rows
   logic             sw_v_ff;
   logic [AW-1:0]    sw_row_ff;
   logic [CNT_W-1:0] run_ff;
   logic [CNT_W:0]   cov_sum;
   logic [CNT_W-1:0] cov, run_in;
   logic             sw_active;
   logic [CNT_W-1:0] cov_mem [MAX_ROWS];

   always_comb begin
      cov_sum   = ((sw_row_ff == '0) ? '0 : (CNT_W+1)'(run_ff)) + (CNT_W+1)'(st_rd_ff);
      cov       = cov_sum[CNT_W-1:0];
      run_in    = cov - en_rd_ff;
      sw_active = CW'(sw_row_ff) < CW'(n_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_v_ff <= 1'b0;
      end else begin
         sw_v_ff <= cmd.sweep_step;
      end
   end

   always_ff @(posedge clock) begin
      sw_row_ff <= row_ff;
      if (sw_v_ff) begin
         run_ff <= run_in;
         if (sw_active) cov_mem[sw_row_ff] <= cov;
      end
   end

   // window pass: add the entering row, drop the leaving one
   logic [AW-1:0]    b_addr;
   logic [CNT_W-1:0] ca_rd_ff, cb_rd_ff;
   logic             ac_v_ff, ac_first_ff, ac_sub_ff, ac_bfirst_ff, ac_late_ff;
   logic [SUM_W-1:0] win_ff, best_ff, win_in;

   assign b_addr = AW'(CW'(row_ff) - CW'(h_eff));

   always_ff @(posedge clock) begin
      if (reset) begin
         ac_v_ff <= 1'b0;
      end else begin
         ac_v_ff <= cmd.win_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.win_step) begin
         ca_rd_ff     <= cov_mem[row_ff];
         cb_rd_ff     <= cov_mem[b_addr];
         ac_first_ff  <= (row_ff == '0);
         ac_sub_ff    <= CW'(row_ff) >= CW'(h_eff);
         ac_bfirst_ff <= (CW'(row_ff) + CW'(1)) == CW'(h_eff);
         ac_late_ff   <= (CW'(row_ff) + CW'(1)) >= CW'(h_eff);
      end
   end

   assign win_in = (ac_first_ff ? '0 : win_ff) + SUM_W'(ca_rd_ff)
                   - (ac_sub_ff ? SUM_W'(cb_rd_ff) : '0);

   always_ff @(posedge clock) begin
      if (ac_v_ff) begin
         win_ff <= win_in;
         if (ac_bfirst_ff) begin
            best_ff <= win_in;
         end else if (ac_late_ff && (win_in > best_ff)) begin
            best_ff <= win_in;
         end
      end
   end

   // result
   logic [SUM_W-1:0] nh_ff;
   logic [OUT_W-1:0] out_ff;
   logic             out_v_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) nh_ff <= SUM_W'(n_eff) * SUM_W'(h_eff);
      if (cmd.load_out) out_ff <= OUT_W'(nh_ff - best_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_v_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_v_ff <= 1'b0;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_min_energy = out_ff;

   always_comb begin
      status.row_last = (row_ff == ROW_LAST);
      status.win_last = CW'(row_ff) == CW'(n_last);
      status.set_done = loaded_ff >= n_eff;
      status.out_free = !out_v_ff || rsp_ready;
   end

endmodule

### sv/interval_coverage_max_window_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_coverage_max_window_unit
// Loads one row interval per column, builds per-row coverage when a set is
// complete and reports count*height minus the best window coverage sum.
//
//   Channel  Dir  Handshake               Word
//   req_bus  in   valid/ready             gap_low[9:0], gap_high[9:0]
//   rsp_bus  out  valid/ready             min_energy[20:0]
//   csr_*    in   csr_we, csr_index[1:0]  csr_wdata[10:0]
//
// An interval word is a store read, then an incremented write back.
// The word that completes a set then starts a sweep over
// every store row (one row per cycle, single store port), a window pass of
// n rows on the coverage store, the multiply and the result load.
// After reset a clearing pass over every store row runs before req_bus.ready.
// A stalled rsp_bus holds the result; the next set loads meanwhile and waits
// only at its own result handoff.
// ----------------------------------------------------------------------------
module interval_coverage_max_window_unit
   import icmw_pkg::*;
#(
   parameter int MAX_ROWS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   icmw_req_if.sink               req_bus,
   icmw_rsp_if.source             rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   icmw_cmd_type    cmd;
   icmw_status_type status;

   icmw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   icmw_dpath #(
      .MAX_ROWS (MAX_ROWS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_gap_low    (req_bus.gap_low),
      .req_gap_high   (req_bus.gap_high),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_min_energy (rsp_bus.min_energy)
   );

endmodule

### sv/icmw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmw_checker
// Port-level checks for the interval coverage max window unit.
// ----------------------------------------------------------------------------
module icmw_checker
   import icmw_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [OUT_W-1:0] rsp_min_energy
);

   // a result word stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_min_energy))
      else $error("result word changed while stalled");

   // each interval word needs its write back before the next is taken
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("interval word taken during write back");

   // reset starts the clearing pass with both sides quiet
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("activity right after reset");

endmodule

bind interval_coverage_max_window_unit icmw_checker u_icmw_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_min_energy (rsp_bus.min_energy)
);

### sim/tb_interval_coverage_max_window_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_coverage_max_window_unit
// Self-checking bench for the interval coverage max window unit. A directed
// table covers register extremes, clamping, swapped bounds, ignored register
// indexes and a set cut short by a lowered column count. Random interval words
// follow: one full 1024-row set, an input backpressure run behind a long
// result stall, and many small sets. Every min_energy word is compared
// against an in-bench model of the row count stores or a value typed in the table.
// ----------------------------------------------------------------------------
module tb_interval_coverage_max_window_unit
   import icmw_pkg::*;
();

   localparam int          MAX_ROWS         = 1024;
   localparam int          HALF_PERIOD      = 4;
   localparam int          SETTLE_CYCLES    = 8;
   localparam int          LONG_HOLD_CYCLES = 6000;
   localparam int          TOTAL_WORDS      = 1650;
   localparam int          MAX_SMALL_PHASES = 40;
   localparam int unsigned CYCLE_LIMIT      = 3_000_000;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = 2'd3;

   typedef enum logic {STEP_WRITE, STEP_WORD} step_kind_type;

   typedef struct packed {
      step_kind_type          kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  value;
      logic [ROW_W-1:0]       lo;
      logic [ROW_W-1:0]       hi;
      logic                   typed;
      logic [OUT_W-1:0]       energy;
   } directed_step_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   icmw_req_if req_bus ();
   icmw_rsp_if rsp_bus ();

   interval_coverage_max_window_unit #(
      .MAX_ROWS (MAX_ROWS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // model of the unit: registers, per-row start/end tallies, words in the set
   logic [COL_W-1:0] column_reg = COLUMN_COUNT_RESET;
   logic [COL_W-1:0] height_reg = CORRIDOR_HEIGHT_RESET;
   int unsigned      start_tally [MAX_ROWS];
   int unsigned      end_tally [MAX_ROWS];
   logic [COL_W-1:0] rows_loaded = '0;

   logic [OUT_W-1:0] pending_energy [$];
   int unsigned      words_sent;
   int unsigned      energy_checked;
   int unsigned      csr_writes;
   int unsigned      error_count;
   int unsigned      cycle_count;
   bit               rsp_stalls_on = 1'b1;
   bit               hold_rsp_request = 1'b0;

   directed_step_type plan [24];

   function automatic int unsigned active_columns();
      if (column_reg == 0) return 1;
      if (column_reg > MAX_ROWS) return MAX_ROWS;
      return 32'(column_reg);
   endfunction

   function automatic void load_interval(input logic [ROW_W-1:0] lo_in,
                                         input logic [ROW_W-1:0] hi_in,
                                         output bit set_done,
                                         output logic [OUT_W-1:0] energy);
      int unsigned n;
      int unsigned h;
      int unsigned lo;
      int unsigned hi;
      int          r;
      longint      run;
      longint      win;
      longint      best;
      longint      total;
      longint      cover_row [MAX_ROWS];
      n  = active_columns();
      lo = 32'(lo_in);
      hi = 32'(hi_in);
      if (lo > hi) begin
         lo = 32'(hi_in);
         hi = 32'(lo_in);
      end
      if (lo > n - 1) lo = n - 1;
      if (hi > n - 1) hi = n - 1;
      start_tally[lo]++;
      end_tally[hi]++;
      rows_loaded++;
      set_done = (rows_loaded >= n);
      energy   = '0;
      if (set_done) begin
         h = (height_reg == 0) ? 1 : 32'(height_reg);
         if (h > n) h = n;
         // coverage of row r: starts through r minus ends through r-1
         run = 0;
         for (r = 0; r < n; r++) begin
            run += start_tally[r];
            if (r > 0) run -= end_tally[r-1];
            cover_row[r] = run;
         end
         win = 0;
         for (r = 0; r < h; r++) win += cover_row[r];
         best = win;
         for (r = h; r < n; r++) begin
            win += cover_row[r] - cover_row[r-h];
            if (win > best) best = win;
         end
         total  = longint'(n) * longint'(h) - best;
         energy = total[OUT_W-1:0];
         foreach (start_tally[i]) begin
            start_tally[i] = 0;
            end_tally[i]   = 0;
         end
         rows_loaded = '0;
      end
   endfunction

   function automatic logic [ROW_W-1:0] pick_row(input int unsigned n);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ROW_W'(n - 1);
         2: return '1;
         3, 4: return ROW_W'($urandom_range(0, 1023));
         default: return ROW_W'($urandom_range(0, n - 1));
      endcase
   endfunction

   task automatic send_word(input logic [ROW_W-1:0] lo, input logic [ROW_W-1:0] hi,
                            input logic typed, input logic [OUT_W-1:0] typed_energy);
      bit               done;
      logic [OUT_W-1:0] energy;
      @(negedge clock);
      req_bus.valid    <= 1'b1;
      req_bus.gap_low  <= lo;
      req_bus.gap_high <= hi;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      load_interval(lo, hi, done, energy);
      if (done) pending_energy.push_back(typed ? typed_energy : energy);
      words_sent++;
   endtask

   task automatic pause_sender(input int unsigned cycles);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // drop valid, let every result out, then give the last word time to retire
   task automatic drain();
      pause_sender(1);
      while (pending_energy.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (index)
         CSR_COLUMN_COUNT:    column_reg = value;
         CSR_CORRIDOR_HEIGHT: height_reg = value;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic send_words(input int unsigned count, input bit gappy);
      int unsigned n;
      repeat (count) begin
         if (gappy && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 16));
         n = active_columns();
         send_word(pick_row(n), pick_row(n), 1'b0, '0);
      end
   endtask

   // result side: random ready bursts, plus one long hold on request
   initial begin : rsp_pacing
      int unsigned burst;
      bit          stall;
      rsp_bus.ready = 1'b0;
      forever begin
         if (hold_rsp_request) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp_request = 1'b0;
         end else begin
            stall = rsp_stalls_on && ($urandom_range(0, 2) == 0);
            burst = $urandom_range(1, 16);
            @(negedge clock);
            rsp_bus.ready <= !stall;
            repeat (burst - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_energy
      logic [OUT_W-1:0] want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_energy.size() == 0) begin
            $display("%0t: min_energy %0d arrived with nothing expected",
                     $time, rsp_bus.min_energy);
            error_count++;
         end else begin
            want = pending_energy.pop_front();
            if (rsp_bus.min_energy !== want) begin
               $display("%0t: min_energy mismatch: expected %0d, actual %0d",
                        $time, want, rsp_bus.min_energy);
               error_count++;
            end
            energy_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached, %0d min_energy words outstanding",
                  $time, pending_energy.size());
         $display("tb_interval_coverage_max_window_unit NOT OK");
         $finish;
      end
   end

   initial begin
      int unsigned cols;
      int unsigned hgt;
      int unsigned n;
      int unsigned phases;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_COLUMN_COUNT;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.gap_low  = '0;
      req_bus.gap_high = '0;
      phases           = 0;

      plan = '{
         // reset settings: 1024 columns, height 1
         '{STEP_WORD,  CSR_COLUMN_COUNT,    11'd0,    10'd0,    10'd1023, 1'b0, 21'd0},
         '{STEP_WORD,  CSR_COLUMN_COUNT,    11'd0,    10'd1023, 10'd1023, 1'b0, 21'd0},
         // lowering the count closes the open set on the next word
         '{STEP_WRITE, CSR_COLUMN_COUNT,    11'd1,    10'd0,    10'd0,    1'b0, 21'd0},
         '{STEP_WORD,  CSR_COLUMN_COUNT,    11'd0,    10'd512,  10'd3,    1'b0, 21'd0},
         '{STEP_WRITE, CSR_CORRIDOR_HEIGHT, 11'd0,    10'd0,    10'd0,    1'b0, 21'd0},
         '{STEP_WORD,  CSR_COLUMN_COUNT,    11'd0,    10'd1023, 10'd0,    1'b1, 21'd0},
         '{STEP_WRITE, CSR_COLUMN_COUNT,    11'd0,    10'd0,    10'd0,    1'b0, 21'd0},
         '{STEP_WORD,  CSR_COLUMN_COUNT,    11'd0,    10'd1023, 10'd1023, 1'b1, 21'd0},
         '{STEP_WRITE, CSR_COLUMN_COUNT,    11'd2,    10'd0,    10'd0,    1'b0, 21'd0},
         '{STEP_WRITE, CSR_CORRIDOR_HEIGHT, 11'd2,    10'd0,    10'd0,    1'b0, 21'd0},
         '{STEP_WORD,  CSR_COLUMN_COUNT,    11'd0,    10'd0,    10'd1023, 1'b0, 21'd0},
         '{STEP_WORD,  CSR_COLUMN_COUNT,    11'd0,    10'd1023, 10'd0,    1'b1, 21'd0},
         '{STEP_WORD,  CSR_COLUMN_COUNT,    11'd0,    10'd1,    10'd1,    1'b0, 21'd0},
         '{STEP_WORD,  CSR_COLUMN_COUNT,    11'd0,    10'd1,    10'd1,    1'b1, 21'd2},
         // height above the column count clamps to it
         '{STEP_WRITE, CSR_CORRIDOR_HEIGHT, 11'd2047, 10'd0,    10'd0,    1'b0, 21'd0},
         '{STEP_WORD,  CSR_COLUMN_COUNT,    11'd0,    10'd1,    10'd0,    1'b0, 21'd0},
         '{STEP_WORD,  CSR_COLUMN_COUNT,    11'd0,    10'd1,    10'd1,    1'b1, 21'd1},
         '{STEP_WRITE, CSR_UNMAPPED_LO,     11'd2047, 10'd0,    10'd0,    1'b0, 21'd0},
         '{STEP_WRITE, CSR_UNMAPPED_HI,     11'd0,    10'd0,    10'd0,    1'b0, 21'd0},
         '{STEP_WRITE, CSR_COLUMN_COUNT,    11'd4,    10'd0,    10'd0,    1'b0, 21'd0},
         '{STEP_WORD,  CSR_COLUMN_COUNT,    11'd0,    10'd0,    10'd3,    1'b0, 21'd0},
         '{STEP_WORD,  CSR_COLUMN_COUNT,    11'd0,    10'd2,    10'd2,    1'b0, 21'd0},
         '{STEP_WRITE, CSR_COLUMN_COUNT,    11'd2,    10'd0,    10'd0,    1'b0, 21'd0},
         '{STEP_WORD,  CSR_COLUMN_COUNT,    11'd0,    10'd3,    10'd3,    1'b0, 21'd0}
      };

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == STEP_WRITE) begin
            drain();
            write_register(plan[i].index, plan[i].value);
         end else begin
            send_word(plan[i].lo, plan[i].hi, plan[i].typed, plan[i].energy);
         end
      end

      // one full-size set; a count above the row limit acts as the limit
      drain();
      write_register(CSR_COLUMN_COUNT, 11'd2047);
      write_register(CSR_CORRIDOR_HEIGHT, CSR_DATA_W'($urandom_range(2, 1023)));
      send_words(MAX_ROWS + $urandom_range(0, 3), 1'b1);

      // hold results long enough that the unit backs up onto its input
      drain();
      write_register(CSR_COLUMN_COUNT, 11'd3);
      write_register(CSR_CORRIDOR_HEIGHT, 11'd2);
      hold_rsp_request = 1'b1;
      send_words(48, 1'b0);

      while (words_sent < TOTAL_WORDS && phases < MAX_SMALL_PHASES) begin
         drain();
         case ($urandom_range(0, 9))
            0: cols = 0;
            1: cols = 1;
            2, 3: cols = $urandom_range(25, 96);
            default: cols = $urandom_range(2, 24);
         endcase
         n = (cols == 0) ? 1 : cols;
         case ($urandom_range(0, 7))
            0: hgt = 0;
            1: hgt = 1;
            2: hgt = n;
            3: hgt = 2047;
            4: hgt = MAX_ROWS;
            default: hgt = $urandom_range(1, n);
         endcase
         write_register(CSR_COLUMN_COUNT, CSR_DATA_W'(cols));
         write_register(CSR_CORRIDOR_HEIGHT, CSR_DATA_W'(hgt));
         send_words($urandom_range(n, 3 * n + 2), $urandom_range(0, 2) != 0);
         phases++;
      end

      // closing stretch at full rate on both sides
      rsp_stalls_on = 1'b0;
      drain();
      n = $urandom_range(2, 16);
      write_register(CSR_COLUMN_COUNT, CSR_DATA_W'(n));
      write_register(CSR_CORRIDOR_HEIGHT, CSR_DATA_W'($urandom_range(1, n)));
      send_words(3 * n, 1'b0);

      drain();
      repeat (MAX_ROWS + 64) @(negedge clock);

      $display("ran %0d interval words and %0d register writes; checked %0d min_energy words",
               words_sent, csr_writes, energy_checked);
      $display("including a full %0d-row set and a long result stall with input backpressure",
               MAX_ROWS);
      if (error_count == 0) begin
         $display("tb_interval_coverage_max_window_unit OK");
      end else begin
         $display("tb_interval_coverage_max_window_unit NOT OK");
      end
      $finish;
   end

endmodule

### files.f
sv/icmw_pkg.sv
sv/icmw_if.sv
sv/icmw_ctrl.sv
sv/icmw_dpath.sv
sv/interval_coverage_max_window_unit.sv
sv/icmw_checker.sv
sim/tb_interval_coverage_max_window_unit.sv
